// ----- hw/rtl/char_counting_line_streamer_assert.svh -----
// Assertion macros used by the line streamer RTL.
`ifndef CHAR_COUNTING_LINE_STREAMER_ASSERT_SVH
`define CHAR_COUNTING_LINE_STREAMER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CCLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CCLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ccls_pkg.sv -----
// Types, constants and helpers for the character-counting line streamer.
package ccls_pkg;

    localparam int LINE_W     = 24;
    localparam int BYTES_W    = 10;
    localparam int TOOL_W     = 16;
    localparam int INFLIGHT_W = 11;
    localparam int MAX_RES    = 6;
    localparam int RES_CNT_W  = 3;

    localparam int DEF_INFLIGHT_DEPTH = 64;
    localparam int DEF_MAX_ADHOC      = 255;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

    localparam int               CFG_IDX_W     = 1;
    localparam logic [BYTES_W-1:0] RX_BYTES_RESET = 10'd128;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RX_BUFFER_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSERVATIVE_MODE = 1'd1;

    typedef enum logic [2:0] {
        OP_START       = 3'd0,
        OP_NEXT_LINE   = 3'd1,
        OP_REPLY_OK    = 3'd2,
        OP_REPLY_ERROR = 3'd3,
        OP_ADHOC       = 3'd4,
        OP_TOOL_DONE   = 3'd5,
        OP_STOP        = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        KIND_SEND        = 3'd0,
        KIND_NEED_NEXT   = 3'd1,
        KIND_PROGRESS    = 3'd2,
        KIND_TOOL_CHANGE = 3'd3,
        KIND_FINISHED    = 3'd4,
        KIND_ERROR       = 3'd5,
        KIND_CMD_RESULT  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LINE_W-1:0]  line_index;
        logic [LINE_W-1:0]  acked_lines;
        logic [BYTES_W-1:0] sent_bytes;
        logic [TOOL_W-1:0]  requested_tool;
        logic               flag;
    } res_t;

    function automatic res_t mk_res(kind_t k, logic [LINE_W-1:0] idx,
                                    logic [LINE_W-1:0] acked,
                                    logic [BYTES_W-1:0] bytes,
                                    logic [TOOL_W-1:0] tool, logic flg);
        res_t r;
        r.kind           = k;
        r.line_index     = idx;
        r.acked_lines    = acked;
        r.sent_bytes     = bytes;
        r.requested_tool = tool;
        r.flag           = flg;
        return r;
    endfunction

endpackage

// ----- hw/rtl/ccls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ccls_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/char_counting_line_streamer.sv -----
// Top level of the character-counting line streamer.
//
// Sender side of character-counting flow control. Each input transfer is one
// event; its state update is done in the cycle it is accepted and its results
// (zero to six) are loaded into a result buffer that drains one transfer per
// cycle while m_tready is high. Events that give at most one result can follow
// back to back while m_tready stays high; an event giving n results holds
// s_tready low until its last result leaves. The sizes of in-flight lines sit
// in a RAM of INFLIGHT_DEPTH entries with a registered read port; the head
// entry is pre-read (with a bypass for a line written into an empty queue) so
// a reply retires it in the same cycle. No clearing pass is needed after reset.
`include "char_counting_line_streamer_assert.svh"

module char_counting_line_streamer
    import ccls_pkg::*;
#(
    parameter int INFLIGHT_DEPTH = DEF_INFLIGHT_DEPTH,
    parameter int MAX_ADHOC      = DEF_MAX_ADHOC
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTES_W-1:0]    cfg_wdata,
    // event stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // line_total, line_bytes, tool_number, pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // opcode, is_tool_marker
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // line_index, acked_lines, sent_bytes,
                                             // requested_tool, flag, pad
    output logic [M_TUSER_W-1:0]  m_tuser,   // kind
    output logic                  m_tlast
);

    localparam int ADDR_W  = $clog2(INFLIGHT_DEPTH);
    localparam int CNT_W   = $clog2(INFLIGHT_DEPTH + 1);
    localparam int ADHOC_W = $clog2(MAX_ADHOC + 1);

    // configuration
    logic [BYTES_W-1:0] rx_bytes_reg;
    logic               cons_mode_reg;

    // stream control state
    logic               streaming_reg,  streaming_next;
    logic               parked_reg,     parked_next;
    logic [TOOL_W-1:0]  ptool_reg,      ptool_next;
    logic [LINE_W-1:0]  total_reg,      total_next;
    logic [LINE_W-1:0]  nidx_reg,       nidx_next;
    logic [LINE_W-1:0]  acked_reg,      acked_next;
    logic [INFLIGHT_W-1:0] ibytes_reg,  ibytes_next;
    logic [CNT_W-1:0]   cnt_reg,        cnt_next;
    logic [ADDR_W-1:0]  head_reg,       head_next;
    logic [ADDR_W-1:0]  tail_reg,       tail_next;
    logic               err_reg,        err_next;
    logic [ADHOC_W-1:0] adhoc_reg,      adhoc_next;
    logic               la_valid_reg,   la_valid_next;
    logic [BYTES_W-1:0] la_bytes_reg,   la_bytes_next;
    logic               la_marker_reg,  la_marker_next;
    logic [TOOL_W-1:0]  la_tool_reg,    la_tool_next;

    // head-of-queue bypass
    logic               byp_reg,        byp_next;
    logic [BYTES_W-1:0] byp_data_reg,   byp_data_next;
    logic [BYTES_W-1:0] ram_q;
    logic [BYTES_W-1:0] head_size;

    // result buffer
    res_t               res_buf_reg [MAX_RES];
    logic [RES_CNT_W-1:0] res_cnt_reg;
    res_t               slot [MAX_RES];
    logic [MAX_RES-1:0] slot_v;
    res_t               load [MAX_RES];
    logic [RES_CNT_W-1:0] load_cnt;

    logic               s_acc;
    logic               m_acc;
    op_t                op;
    logic               push;
    logic [BYTES_W-1:0] push_data;
    logic               pump_en;

    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign s_tready  = (res_cnt_reg == '0) || ((res_cnt_reg == RES_CNT_W'(1)) && m_tready);
    assign op        = op_t'(s_tuser[2:0]);
    assign head_size = byp_reg ? byp_data_reg : ram_q;

    ccls_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (INFLIGHT_DEPTH)
    ) u_sizes (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (push_data),
        .rd_addr (head_next),
        .rd_data (ram_q)
    );

    // Event decode, single-step pump and finish check
    always_comb begin
        logic [INFLIGHT_W-1:0] room_need;
        logic                  err_reply;

        streaming_next = streaming_reg;
        parked_next    = parked_reg;
        ptool_next     = ptool_reg;
        total_next     = total_reg;
        nidx_next      = nidx_reg;
        acked_next     = acked_reg;
        ibytes_next    = ibytes_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        err_next       = err_reg;
        adhoc_next     = adhoc_reg;
        la_valid_next  = la_valid_reg;
        la_bytes_next  = la_bytes_reg;
        la_marker_next = la_marker_reg;
        la_tool_next   = la_tool_reg;
        byp_data_next  = byp_data_reg;
        push           = 1'b0;
        push_data      = la_bytes_reg;
        pump_en        = 1'b0;
        slot_v         = '0;
        room_need      = '0;
        err_reply      = (op == OP_REPLY_ERROR);
        for (int i = 0; i < MAX_RES; i++) begin
            slot[i] = '0;
        end

        if (s_acc) begin
            unique case (op)
                OP_START: begin
                    if (!streaming_reg) begin
                        total_next     = s_tdata[23:0];
                        nidx_next      = '0;
                        acked_next     = '0;
                        cnt_next       = '0;
                        head_next      = '0;
                        tail_next      = '0;
                        ibytes_next    = '0;
                        err_next       = 1'b0;
                        parked_next    = 1'b0;
                        la_valid_next  = 1'b0;
                        streaming_next = (s_tdata[23:0] != '0);
                        slot_v[1]      = 1'b1;
                        slot[1]        = mk_res(KIND_PROGRESS, '0, '0, '0, '0, 1'b0);
                        if (s_tdata[23:0] != '0) begin
                            slot_v[2] = 1'b1;
                            slot[2]   = mk_res(KIND_NEED_NEXT, '0, '0, '0, '0, 1'b0);
                        end
                    end
                end
                OP_NEXT_LINE: begin
                    if (streaming_reg && !la_valid_reg) begin
                        la_valid_next  = 1'b1;
                        la_bytes_next  = s_tdata[33:24];
                        la_marker_next = s_tuser[3];
                        la_tool_next   = s_tdata[49:34];
                    end
                    pump_en = 1'b1;
                end
                OP_REPLY_OK, OP_REPLY_ERROR: begin
                    priority if (adhoc_reg != '0) begin
                        // reply belongs to an ad-hoc command
                        adhoc_next = adhoc_reg - ADHOC_W'(1);
                        if (err_reply) begin
                            slot_v[0] = 1'b1;
                            slot[0]   = mk_res(KIND_ERROR, '0, '0, '0, '0, 1'b0);
                        end
                        pump_en = (adhoc_reg == ADHOC_W'(1));
                    end else if (streaming_reg && cnt_reg != '0) begin
                        // retire the oldest stream line
                        ibytes_next = ibytes_reg - {1'b0, head_size};
                        head_next   = (head_reg == ADDR_W'(INFLIGHT_DEPTH - 1)) ?
                                      '0 : head_reg + ADDR_W'(1);
                        cnt_next    = cnt_reg - CNT_W'(1);
                        acked_next  = acked_reg + LINE_W'(1);
                        if (err_reply) begin
                            err_next  = 1'b1;
                            slot_v[0] = 1'b1;
                            slot[0]   = mk_res(KIND_ERROR, acked_reg, '0, '0, '0, 1'b0);
                        end
                        slot_v[1] = 1'b1;
                        slot[1]   = mk_res(KIND_PROGRESS, '0, acked_next, '0, '0, 1'b0);
                        pump_en   = 1'b1;
                    end else if (err_reply) begin
                        slot_v[0] = 1'b1;
                        slot[0]   = mk_res(KIND_ERROR, '0, '0, '0, '0, 1'b0);
                    end
                end
                OP_ADHOC: begin
                    slot_v[0] = 1'b1;
                    if ((!streaming_reg || parked_reg) &&
                        adhoc_reg < ADHOC_W'(MAX_ADHOC)) begin
                        adhoc_next = adhoc_reg + ADHOC_W'(1);
                        slot[0]    = mk_res(KIND_CMD_RESULT, '0, '0, '0, '0, 1'b1);
                    end else begin
                        slot[0]    = mk_res(KIND_CMD_RESULT, '0, '0, '0, '0, 1'b0);
                    end
                end
                OP_TOOL_DONE: begin
                    if (streaming_reg && parked_reg) begin
                        parked_next = 1'b0;
                        pump_en     = 1'b1;
                    end
                end
                OP_STOP: begin
                    streaming_next = 1'b0;
                    parked_next    = 1'b0;
                    cnt_next       = '0;
                    head_next      = '0;
                    tail_next      = '0;
                    ibytes_next    = '0;
                    adhoc_next     = '0;
                    la_valid_next  = 1'b0;
                    if (streaming_reg) begin
                        slot_v[5] = 1'b1;
                        slot[5]   = mk_res(KIND_FINISHED, '0, '0, '0, '0, 1'b0);
                    end
                end
                default: begin
                end
            endcase
        end

        // Pump: at most one line moves per event since it consumes the lookahead
        room_need = ibytes_next + {1'b0, la_bytes_next};
        if (pump_en && streaming_next && !parked_next && adhoc_next == '0 &&
            nidx_next < total_next && la_valid_next) begin
            if (la_marker_next) begin
                if (cnt_next == '0) begin
                    // park in front of the tool change
                    parked_next   = 1'b1;
                    ptool_next    = la_tool_next;
                    la_valid_next = 1'b0;
                    slot_v[2]     = 1'b1;
                    slot[2]       = mk_res(KIND_PROGRESS, '0, acked_next + LINE_W'(1),
                                           '0, '0, 1'b0);
                    slot_v[3]     = 1'b1;
                    slot[3]       = mk_res(KIND_TOOL_CHANGE, nidx_next, '0, '0,
                                           la_tool_next, 1'b0);
                    acked_next    = acked_next + LINE_W'(1);
                    nidx_next     = nidx_next + LINE_W'(1);
                    if (nidx_next < total_next) begin
                        slot_v[4] = 1'b1;
                        slot[4]   = mk_res(KIND_NEED_NEXT, nidx_next, '0, '0, '0, 1'b0);
                    end
                end
            end else if (!(cons_mode_reg && cnt_next != '0) &&
                         room_need <= {1'b0, rx_bytes_reg} &&
                         cnt_next < CNT_W'(INFLIGHT_DEPTH)) begin
                // send the line and queue its size
                push          = 1'b1;
                push_data     = la_bytes_next;
                if (cnt_next == '0) begin
                    byp_data_next = la_bytes_next;
                end
                tail_next     = (tail_reg == ADDR_W'(INFLIGHT_DEPTH - 1)) ?
                                '0 : tail_reg + ADDR_W'(1);
                cnt_next      = cnt_next + CNT_W'(1);
                ibytes_next   = room_need;
                la_valid_next = 1'b0;
                slot_v[2]     = 1'b1;
                slot[2]       = mk_res(KIND_SEND, nidx_next, '0, la_bytes_next, '0, 1'b0);
                nidx_next     = nidx_next + LINE_W'(1);
                if (nidx_next < total_next) begin
                    slot_v[3] = 1'b1;
                    slot[3]   = mk_res(KIND_NEED_NEXT, nidx_next, '0, '0, '0, 1'b0);
                end
            end
        end

        // End the stream once every line is acknowledged
        if (pump_en && streaming_next && acked_next >= total_next) begin
            streaming_next = 1'b0;
            slot_v[5]      = 1'b1;
            slot[5]        = mk_res(KIND_FINISHED, '0, '0, '0, '0, !err_next);
        end
    end

    // Track whether the head entry was written while the queue was empty
    always_comb begin
        byp_next = byp_reg;
        if (head_next != head_reg) begin
            byp_next = 1'b0;
        end
        if (push && (byp_data_next == push_data) && (tail_reg == head_next) &&
            (cnt_next == CNT_W'(1))) begin
            byp_next = 1'b1;
        end
    end

    // Pack the present results in order
    always_comb begin
        logic [RES_CNT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            load[i] = '0;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            if (slot_v[i]) begin
                load[pos] = slot[i];
                pos       = pos + RES_CNT_W'(1);
            end
        end
        load_cnt = pos;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_bytes_reg  <= RX_BYTES_RESET;
            cons_mode_reg <= 1'b0;
            streaming_reg <= 1'b0;
            parked_reg    <= 1'b0;
            ptool_reg     <= '0;
            total_reg     <= '0;
            nidx_reg      <= '0;
            acked_reg     <= '0;
            ibytes_reg    <= '0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            err_reg       <= 1'b0;
            adhoc_reg     <= '0;
            la_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            res_cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_RX_BUFFER_BYTES:   rx_bytes_reg  <= cfg_wdata;
                    CFG_CONSERVATIVE_MODE: cons_mode_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            streaming_reg <= streaming_next;
            parked_reg    <= parked_next;
            ptool_reg     <= ptool_next;
            total_reg     <= total_next;
            nidx_reg      <= nidx_next;
            acked_reg     <= acked_next;
            ibytes_reg    <= ibytes_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            err_reg       <= err_next;
            adhoc_reg     <= adhoc_next;
            la_valid_reg  <= la_valid_next;
            byp_reg       <= byp_next;
            priority if (s_acc) begin
                res_cnt_reg <= load_cnt;
            end else if (m_acc) begin
                res_cnt_reg <= res_cnt_reg - RES_CNT_W'(1);
            end
        end
    end

    // Payload registers: lookahead, bypass data and result buffer
    always_ff @(posedge aclk) begin
        la_bytes_reg  <= la_bytes_next;
        la_marker_reg <= la_marker_next;
        la_tool_reg   <= la_tool_next;
        byp_data_reg  <= byp_data_next;
        if (s_acc) begin
            for (int i = 0; i < MAX_RES; i++) begin
                res_buf_reg[i] <= load[i];
            end
        end else if (m_acc) begin
            // advance the buffer by one transfer
            for (int i = 0; i < MAX_RES - 1; i++) begin
                res_buf_reg[i] <= res_buf_reg[i + 1];
            end
        end
    end

    // Result channel
    assign m_tvalid = (res_cnt_reg != '0);
    assign m_tlast  = (res_cnt_reg == RES_CNT_W'(1));
    assign m_tuser  = res_buf_reg[0].kind;
    assign m_tdata  = {5'b0, res_buf_reg[0].flag, res_buf_reg[0].requested_tool,
                       res_buf_reg[0].sent_bytes, res_buf_reg[0].acked_lines,
                       res_buf_reg[0].line_index};

    `CCLS_ASSERT_NOW(a_cnt_bounded, 1'b1, cnt_reg <= CNT_W'(INFLIGHT_DEPTH), "in-flight count above depth")
    `CCLS_ASSERT_NOW(a_empty_no_bytes, cnt_reg == '0, ibytes_reg == '0, "bytes left with empty queue")
    `CCLS_ASSERT_NOW(a_stream_open, streaming_reg, acked_reg < total_reg, "stream running with all lines acked")
    `CCLS_ASSERT_NOW(a_hold_input, res_cnt_reg > RES_CNT_W'(1), !s_tready, "input taken while results pending")
    `CCLS_ASSERT_NEXT(a_stop_halts, s_acc && op == OP_STOP, !streaming_reg && cnt_reg == '0, "stop left stream running")

endmodule
